// File: rtl/core/plac_pkg.sv
// Shared types and constants for the positional array list.
package plac_pkg;

  localparam int DATA_W        = 32;
  localparam int POS_W         = 6;
  localparam int FUNC_W        = 2;
  localparam int LEN_W         = 6;
  localparam int DEPTH_DEFAULT = 32;

  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] item_value;
    logic [LEN_W-1:0]         list_length;
  } rsp_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

// File: rtl/core/positional_array_list_unit.sv
// Top level of the positional array list: decode, cell chain and response register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------
//   request | req_valid | req_stall | req (plac_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (plac_pkg::rsp_t)
//
// One request per cycle while req_stall is low; cells from the position on shift
// as the request is taken, and the result is registered for the next cycle.
// Read selects one of the first 63 cells through a one-hot AND-OR.
// rst clears the length and the result valid; cell contents are not reset.
// req_stall is high only while a held result waits under rsp_stall.
module positional_array_list_unit #(
  parameter int DEPTH = plac_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  plac_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output plac_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > plac_pkg::POS_W) ? CNT_W : plac_pkg::POS_W;
  localparam int RD_N  = (DEPTH < 63) ? DEPTH : 63;

  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   count_next;
  logic                               acc;
  logic [CW-1:0]                      pos_ext;
  logic [CW-1:0]                      cnt_ext;
  logic [CW-1:0]                      pos_m1;
  logic [CW-1:0]                      cnt_m1;
  logic                               pos_nz;
  logic                               in_len;
  logic                               full;
  logic                               ok_c;
  logic                               ret_c;
  plac_pkg::cell_ctrl_t               ctrl;
  logic signed [plac_pkg::DATA_W-1:0] rd_word;
  logic signed [plac_pkg::DATA_W-1:0] vals [DEPTH];
  plac_pkg::rsp_t                     rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign acc       = req_valid && !req_stall;

  assign pos_ext = CW'(req.position);
  assign cnt_ext = CW'(count);
  assign pos_m1  = pos_ext - CW'(1);
  assign cnt_m1  = cnt_ext - CW'(1);
  assign pos_nz  = (req.position != '0);
  assign in_len  = pos_nz && (pos_ext <= cnt_ext);
  assign full    = (count == CNT_W'(DEPTH));

  always_comb begin
    ok_c  = 1'b0;
    ret_c = 1'b0;
    ctrl  = '0;
    case (req.func)
      plac_pkg::FUNC_READ: begin
        ok_c  = in_len;
        ret_c = in_len;
      end
      plac_pkg::FUNC_INSERT: begin
        ok_c     = !full && pos_nz && (pos_ext <= (cnt_ext + CW'(1)));
        ctrl.ins = acc && ok_c;
      end
      plac_pkg::FUNC_DELETE: begin
        ok_c     = in_len;
        ret_c    = in_len;
        ctrl.del = acc && ok_c;
      end
      default: begin
        ok_c  = 1'b0;
        ret_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.del) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_m1 == CW'(i)) begin
        rd_word = rd_word | vals[i];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    plac_cell #(
      .CELL_IDX(g),
      .CW      (CW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pos_m1   (pos_m1),
      .cnt_m1   (cnt_m1),
      .new_value(req.new_value),
      .left     (vals[(g == 0) ? 0 : g - 1]),
      .right    (vals[(g == DEPTH - 1) ? g : g + 1]),
      .value    (vals[g])
    );
  end

  always_comb begin
    rsp_next.ok          = ok_c;
    rsp_next.item_value  = ret_c ? rd_word : '0;
    rsp_next.list_length = plac_pkg::LEN_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_match: assert property (@(posedge clk) disable iff (rst)
    acc |=> rsp.list_length == plac_pkg::LEN_W'(count))
    else $error("result length differs from stored length");

  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    acc && !ok_c |=> count == $past(count))
    else $error("failed request changed the length");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    acc |=> rsp.ok || (rsp.item_value == '0))
    else $error("failed request returned a nonzero word");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    acc |=> count <= CNT_W'(DEPTH))
    else $error("length beyond depth");
`endif

endmodule

// File: rtl/core/plac_cell.sv
// One list entry: holds its word, takes the new word or its left neighbor's on insert, its right neighbor's on delete.
module plac_cell #(
  parameter int CELL_IDX = 0,
  parameter int CW       = 6
) (
  input  logic                               clk,
  input  plac_pkg::cell_ctrl_t               ctrl,
  input  logic [CW-1:0]                      pos_m1,
  input  logic [CW-1:0]                      cnt_m1,
  input  logic signed [plac_pkg::DATA_W-1:0] new_value,
  input  logic signed [plac_pkg::DATA_W-1:0] left,
  input  logic signed [plac_pkg::DATA_W-1:0] right,
  output logic signed [plac_pkg::DATA_W-1:0] value
);

  localparam logic [CW-1:0] MY_IDX = CW'(CELL_IDX);

  always_ff @(posedge clk) begin
    if (ctrl.ins && (MY_IDX >= pos_m1)) begin
      value <= (MY_IDX == pos_m1) ? new_value : left;
    end else if (ctrl.del && (MY_IDX >= pos_m1) && (MY_IDX < cnt_m1)) begin
      value <= right;
    end
  end

endmodule
